### rtl/cet_pkg.sv
`timescale 1ns / 1ps

package cet_pkg;

    // Input command codes.
    localparam logic [1:0] CMD_DUE  = 2'd0;
    localparam logic [1:0] CMD_INIT = 2'd1;
    localparam logic [1:0] CMD_LOAD = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_LIST_MODE    = 3'd0;
    localparam logic [2:0] REG_FIRST_CYCLE  = 3'd1;
    localparam logic [2:0] REG_CYCLE_PERIOD = 3'd2;
    localparam logic [2:0] REG_LAST_CYCLE   = 3'd3;
    localparam logic [2:0] REG_LIST_COUNT   = 3'd4;

    localparam int CYC_W = 31;
    localparam int S_DATA_W = 104;
    localparam int M_DATA_W = 8;

    typedef struct packed {
        logic capture;
        logic write_entry;
        logic div_start;
        logic scan_start;
        logic load_result;
    } cet_cmd_t;

    typedef struct packed {
        logic is_load;
        logic is_check;
        logic is_due;
        logic list_mode;
        logic div_done;
        logic scan_done;
    } cet_stat_t;

endpackage

### rtl/cet_div.sv
`timescale 1ns / 1ps

module cet_div import cet_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [CYC_W-1:0]   divisor,
    input  logic [31:0]        dvd_a,
    input  logic [31:0]        dvd_b,
    output logic               done,
    output logic [CYC_W-1:0]   rem_a,
    output logic [CYC_W-1:0]   rem_b
);

    // Two restoring remainder lanes share one counter; one dividend bit per cycle.
    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] ra_reg, ra_next, rb_reg, rb_next;
    logic [31:0] da_reg, da_next, db_reg, db_next;
    logic [31:0] ta, tb, dvs;

    assign dvs = {1'b0, divisor};
    assign ta  = {ra_reg[30:0], da_reg[31]};
    assign tb  = {rb_reg[30:0], db_reg[31]};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        ra_next   = ra_reg;
        rb_next   = rb_reg;
        da_next   = da_reg;
        db_next   = db_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd31;
            ra_next   = '0;
            rb_next   = '0;
            da_next   = dvd_a;
            db_next   = dvd_b;
        end else if (busy_reg) begin
            ra_next = (ta >= dvs) ? ta - dvs : ta;
            rb_next = (tb >= dvs) ? tb - dvs : tb;
            da_next = {da_reg[30:0], 1'b0};
            db_next = {db_reg[30:0], 1'b0};
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        ra_reg <= ra_next;
        rb_reg <= rb_next;
        da_reg <= da_next;
        db_reg <= db_next;
    end

    assign done  = busy_reg && (cnt_reg == 5'd0);
    assign rem_a = ra_reg[CYC_W-1:0];
    assign rem_b = rb_reg[CYC_W-1:0];

endmodule

### rtl/cet_dpath.sv
`timescale 1ns / 1ps

module cet_dpath import cet_pkg::*; #(
    parameter int LIST_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cet_cmd_t            ctl,
    output cet_stat_t           stat,
    input  logic [S_DATA_W-1:0] in_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic                fired
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [8:0] DEPTH_W = 9'(LIST_DEPTH);

    // Configuration registers.
    logic             list_mode_reg;
    logic [CYC_W-1:0] first_cycle_reg;
    logic [CYC_W-1:0] cycle_period_reg;
    logic [31:0]      last_cycle_reg;
    logic [4:0]       list_count_reg;

    // Captured item.
    logic [1:0]       cmd_reg;
    logic [CYC_W-1:0] cyc_reg, step_reg, val_reg;
    logic [3:0]       idx_reg;

    logic             fired_reg, fired_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            list_mode_reg    <= 1'b0;
            first_cycle_reg  <= '0;
            cycle_period_reg <= CYC_W'(1);
            last_cycle_reg   <= '1;
            list_count_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_LIST_MODE:    list_mode_reg    <= cfg_data[0];
                REG_FIRST_CYCLE:  first_cycle_reg  <= cfg_data[CYC_W-1:0];
                REG_CYCLE_PERIOD: cycle_period_reg <= cfg_data[CYC_W-1:0];
                REG_LAST_CYCLE:   last_cycle_reg   <= cfg_data;
                REG_LIST_COUNT:   list_count_reg   <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            cmd_reg  <= in_data[1:0];
            cyc_reg  <= in_data[32:2];
            step_reg <= in_data[63:33];
            idx_reg  <= in_data[67:64];
            val_reg  <= in_data[98:68];
        end
    end

    // Periodic schedule arithmetic.
    logic [31:0]      cyc32, step32, start32, end32, span32;
    logic [CYC_W-1:0] per_eff, gap, rem_a, rem_b;
    logic             stop_ok, at_or_after, div_done;

    assign cyc32   = {1'b0, cyc_reg};
    assign step32  = {1'b0, step_reg};
    assign start32 = {1'b0, first_cycle_reg};
    assign end32   = cyc32 + step32;
    assign span32  = end32 - start32;
    assign per_eff = (cycle_period_reg == '0) ? CYC_W'(1) : cycle_period_reg;
    assign stop_ok = last_cycle_reg[31] || (cyc32 <= last_cycle_reg);
    assign at_or_after = (cyc_reg >= first_cycle_reg);
    assign gap     = at_or_after ? cyc_reg - first_cycle_reg : first_cycle_reg - cyc_reg;

    cet_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctl.div_start),
        .divisor (per_eff),
        .dvd_a   ({1'b0, gap}),
        .dvd_b   (span32),
        .done    (div_done),
        .rem_a   (rem_a),
        .rem_b   (rem_b)
    );

    // Below the start the old interval index truncates toward zero, so the next
    // boundary sits one full period beyond the remainder.
    logic [31:0] need_after, need_before;
    logic        due_hit, init_hit;

    assign need_after  = {1'b0, per_eff - rem_a};
    assign need_before = {1'b0, rem_a} + {1'b0, per_eff};
    assign due_hit  = stop_ok && (end32 >= start32) &&
                      ((rem_b == '0) ||
                       (at_or_after ? (need_after <= step32) : (need_before <= step32)));
    assign init_hit = stop_ok && at_or_after;

    // Cycle list table and its scan, one entry per cycle.
    logic [CYC_W-1:0] list_mem [LIST_DEPTH];
    logic [CYC_W-1:0] rd_data_reg;
    logic [8:0]       idx9, count9, n9;
    logic [CW-1:0]    scan_n, scan_idx_reg, scan_idx_next, scan_inc;
    logic             scan_busy_reg, scan_busy_next, pend_reg, pend_next;
    logic             hit_reg, hit_next;
    logic [31:0]      target;

    assign idx9   = {5'b0, idx_reg};
    assign count9 = {4'b0, list_count_reg};
    assign n9     = (count9 > DEPTH_W) ? DEPTH_W : count9;
    assign scan_n = n9[CW-1:0];
    assign scan_inc = scan_idx_reg + CW'(1);
    assign target = (cmd_reg == CMD_DUE) ? end32 : cyc32;

    always_ff @(posedge aclk) begin
        if (ctl.write_entry && (idx9 < DEPTH_W)) begin
            list_mem[idx9[AW-1:0]] <= val_reg;
        end
        rd_data_reg <= list_mem[scan_idx_reg[AW-1:0]];
    end

    always_comb begin
        scan_idx_next  = scan_idx_reg;
        scan_busy_next = scan_busy_reg;
        pend_next      = 1'b0;
        hit_next       = hit_reg;
        if (ctl.scan_start) begin
            scan_idx_next  = '0;
            scan_busy_next = (scan_n != '0);
            hit_next       = 1'b0;
        end else begin
            if (scan_busy_reg) begin
                pend_next     = 1'b1;
                scan_idx_next = scan_inc;
                if (scan_inc == scan_n) begin
                    scan_busy_next = 1'b0;
                end
            end
            if (pend_reg && ({1'b0, rd_data_reg} == target)) begin
                hit_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_busy_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end else begin
            scan_busy_reg <= scan_busy_next;
            pend_reg      <= pend_next;
        end
        scan_idx_reg <= scan_idx_next;
        hit_reg      <= hit_next;
    end

    always_comb begin
        fired_next = fired_reg;
        if (ctl.load_result) begin
            priority if (!stat.is_check) begin
                fired_next = 1'b0;
            end else if (list_mode_reg) begin
                fired_next = hit_reg;
            end else if (cmd_reg == CMD_DUE) begin
                fired_next = due_hit;
            end else begin
                fired_next = init_hit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        fired_reg <= fired_next;
    end

    assign fired = fired_reg;

    assign stat.is_load   = (cmd_reg == CMD_LOAD);
    assign stat.is_check  = (cmd_reg == CMD_DUE) || (cmd_reg == CMD_INIT);
    assign stat.is_due    = (cmd_reg == CMD_DUE);
    assign stat.list_mode = list_mode_reg;
    assign stat.div_done  = div_done;
    assign stat.scan_done = !scan_busy_reg && !pend_reg;

endmodule

### rtl/cet_ctrl.sv
`timescale 1ns / 1ps

module cet_ctrl import cet_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  cet_stat_t stat,
    output cet_cmd_t  ctl
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ctl.capture = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP: begin
                priority if (stat.is_load) begin
                    ctl.write_entry = 1'b1;
                    state_next      = S_DONE;
                end else if (stat.is_check && stat.list_mode) begin
                    ctl.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end else if (stat.is_due) begin
                    ctl.div_start = 1'b1;
                    state_next    = S_DIV;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DIV: begin
                if (stat.div_done) begin
                    state_next = S_DONE;
                end
            end
            S_SCAN: begin
                if (stat.scan_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    ctl.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        priority if (ctl.load_result) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/cycle_event_trigger.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid/s_tready    command, current_cycle, cycle_step, entry_index,
//                                           entry_value
// m_        out        m_tvalid/m_tready    fired
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Items are handled one at a time. A periodic due check waits on the 32-step
// remainder unit; a list check reads one table entry per cycle, none for an
// empty list, with list_count limited to the table depth; other commands need
// neither unit.
// A finished result waits in the output register while the next item is taken.
// Reset is synchronous; the list table is not cleared and must be loaded before use.
module cycle_event_trigger import cet_pkg::*; #(
    parameter int LIST_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [1:0] command, [32:2] current_cycle, [63:33] cycle_step,
    // [67:64] entry_index, [98:68] entry_value, rest zero
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [0] fired, rest zero
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    cet_cmd_t  ctl;
    cet_stat_t stat;
    logic      fired;

    // The user must change configuration only while idle; the block does not enforce this and holds cfg_ready high.
    assign cfg_ready = 1'b1;
    assign m_tdata   = {{(M_DATA_W-1){1'b0}}, fired};

    cet_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    cet_dpath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .stat      (stat),
        .in_data   (s_tdata),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fired     (fired)
    );

endmodule

### tb/cycle_event_trigger_test.sv
`timescale 1ns / 1ps

module cycle_event_trigger_test;
    import cet_pkg::*;

    localparam logic [1:0]  CMD_NONE     = 2'd3;
    localparam int          LIST_DEPTH   = 16;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 60;
    localparam longint      CYC_TOP      = 64'h7FFF_FFFF;
    localparam logic [30:0] CYC_MAX      = 31'h7FFF_FFFF;
    localparam logic [31:0] NO_END       = 32'hFFFF_FFFF;

    // Fields of one input transfer, last field in the lowest bits.
    typedef struct packed {
        logic [30:0] entry_value;
        logic [3:0]  entry_index;
        logic [30:0] cycle_step;
        logic [30:0] current_cycle;
        logic [1:0]  command;
    } trig_item_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // [1:0] command, [32:2] current_cycle, [63:33] cycle_step,
    // [67:64] entry_index, [98:68] entry_value, rest zero
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // [0] fired, rest zero
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [2:0]          cfg_index = REG_LIST_MODE;
    logic [31:0]         cfg_data = '0;

    // Schedule as the block should hold it.
    logic        sch_list_mode = 1'b0;
    logic [30:0] sch_first = '0;
    logic [30:0] sch_period = 31'd1;
    logic [31:0] sch_last = NO_END;
    logic [4:0]  sch_count = '0;
    logic [30:0] sch_table [LIST_DEPTH];

    bit expected_fired [$];
    int errors = 0;
    int cycle_count = 0;
    bit no_idle = 1'b0;
    int hold_len = 0;
    int hold_req = 0;

    cycle_event_trigger #(.LIST_DEPTH(LIST_DEPTH)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off when the stimulus asks for one.
    always @(posedge aclk) begin : result_ready
        int hold_left;
        int hold_ack;
        if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= 8);
        end
    end

    always @(posedge aclk) begin : check_results
        bit want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_fired.size() == 0) begin
                errors++;
                $error("fired: expected no transfer, got %0d", m_tdata[0]);
            end else begin
                want = expected_fired.pop_front();
                if (m_tdata[0] !== want) begin
                    errors++;
                    $error("fired: expected %0d, got %0d", want, m_tdata[0]);
                end
            end
        end
    end

    function automatic bit table_holds(longint target);
        int n;
        n = (int'(sch_count) > LIST_DEPTH) ? LIST_DEPTH : int'(sch_count);
        for (int i = 0; i < n; i++)
            if (longint'(sch_table[i]) == target)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic longint stop_cycle();
        longint stop;
        stop = $signed(sch_last);
        return stop;
    endfunction

    function automatic bit due_fires(longint cyc, longint step);
        longint start, per, stop, reach, q, boundary;
        start = longint'(sch_first);
        per = (sch_period == 0) ? 1 : longint'(sch_period);
        stop = stop_cycle();
        reach = cyc + step;
        if (sch_list_mode)
            return table_holds(reach);
        if ((stop > 0 && cyc > stop) || reach < start)
            return 1'b0;
        if (!(stop < 0 || cyc <= stop))
            return 1'b0;
        if ((reach - start) % per == 0)
            return 1'b1;
        // Signed division truncates toward zero, also below the start cycle.
        q = (cyc - start) / per;
        boundary = (q + 1) * per + start;
        return boundary <= reach;
    endfunction

    function automatic bit init_fires(longint cyc);
        longint start, stop;
        start = longint'(sch_first);
        stop = stop_cycle();
        if (sch_list_mode)
            return table_holds(cyc);
        if ((stop > 0 && cyc > stop) || cyc < start)
            return 1'b0;
        return (stop < 0 || cyc <= stop) && cyc >= start;
    endfunction

    function automatic bit predict_fired(trig_item_t it);
        case (it.command)
            CMD_DUE:  return due_fires(longint'(it.current_cycle), longint'(it.cycle_step));
            CMD_INIT: return init_fires(longint'(it.current_cycle));
            CMD_LOAD: begin
                sch_table[it.entry_index] = it.entry_value;
                return 1'b0;
            end
            default:  return 1'b0;
        endcase
    endfunction

    function automatic logic [30:0] clamp_cyc(longint v);
        if (v < 0)
            return '0;
        if (v > CYC_TOP)
            return CYC_MAX;
        return v[30:0];
    endfunction

    function automatic trig_item_t make_item(logic [1:0] command, logic [30:0] cyc,
                                             logic [30:0] step, logic [3:0] index = '0,
                                             logic [30:0] value = '0);
        trig_item_t it;
        it.command = command;
        it.current_cycle = cyc;
        it.cycle_step = step;
        it.entry_index = index;
        it.entry_value = value;
        return it;
    endfunction

    // Most checks land near schedule boundaries or table entries; the rest are unbiased.
    function automatic trig_item_t random_item();
        trig_item_t it;
        int pick, n, j, k, d;
        longint per, anchor, span;
        pick = $urandom_range(99);
        it.command = (pick < 45) ? CMD_DUE : (pick < 80) ? CMD_INIT :
                     (pick < 94) ? CMD_LOAD : CMD_NONE;
        it.current_cycle = 31'($urandom);
        it.cycle_step = 31'($urandom);
        it.entry_index = 4'($urandom);
        it.entry_value = 31'($urandom);
        if ((it.command == CMD_DUE || it.command == CMD_INIT) && $urandom_range(3) != 0) begin
            if (sch_list_mode) begin
                n = (int'(sch_count) > LIST_DEPTH) ? LIST_DEPTH : int'(sch_count);
                if (n > 0) begin
                    j = $urandom_range(n - 1);
                    d = ($urandom_range(5) == 0) ? 1 : 0;
                    anchor = longint'(sch_table[j]);
                    it.cycle_step = 31'(longint'($urandom) % (anchor + 1));
                    if (it.command == CMD_DUE)
                        it.current_cycle = clamp_cyc(anchor - it.cycle_step + d);
                    else
                        it.current_cycle = clamp_cyc(anchor + d);
                end
            end else begin
                per = (sch_period == 0) ? 1 : longint'(sch_period);
                k = $urandom_range(6);
                k = k - 2;
                d = $urandom_range(4);
                d = d - 2;
                if ($urandom_range(2) == 0 && !sch_last[31])
                    anchor = longint'(sch_last) + d;
                else
                    anchor = longint'(sch_first) + longint'(k) * per + d;
                it.current_cycle = clamp_cyc(anchor);
                span = per * 2 + 4;
                if (span > CYC_TOP)
                    span = CYC_TOP;
                if ($urandom_range(3) != 0)
                    it.cycle_step = 31'(longint'($urandom) % span);
            end
        end
        return it;
    endfunction

    task automatic send_item(input trig_item_t it);
        if (!no_idle) begin
            while ($urandom_range(99) < 8) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_DATA_W - $bits(trig_item_t)){1'b0}}, it};
        do @(posedge aclk); while (!s_tready);
        expected_fired = {expected_fired, predict_fired(it)};
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_fired.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            REG_LIST_MODE:    sch_list_mode = value[0];
            REG_FIRST_CYCLE:  sch_first = value[30:0];
            REG_CYCLE_PERIOD: sch_period = value[30:0];
            REG_LAST_CYCLE:   sch_last = value;
            REG_LIST_COUNT:   sch_count = value[4:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input logic mode, input logic [30:0] first,
                             input logic [30:0] period, input logic [31:0] last,
                             input logic [4:0] count);
        wait_idle();
        write_reg(REG_LIST_MODE, 32'(mode));
        write_reg(REG_FIRST_CYCLE, 32'(first));
        write_reg(REG_CYCLE_PERIOD, 32'(period));
        write_reg(REG_LAST_CYCLE, last);
        write_reg(REG_LIST_COUNT, 32'(count));
    endtask

    // Schedule left by reset: every cycle from zero on, no end.
    task automatic test_reset_schedule();
        send_item(make_item(CMD_DUE, '0, '0));
        send_item(make_item(CMD_DUE, CYC_MAX, CYC_MAX));
        send_item(make_item(CMD_INIT, CYC_MAX, '0));
        send_item(make_item(CMD_NONE, CYC_MAX, CYC_MAX, 4'hF, CYC_MAX));
    endtask

    task automatic test_periodic_rules();
        configure(1'b0, 31'd100, 31'd7, 32'd200, 5'd0);
        send_item(make_item(CMD_DUE, 31'd50, 31'd10));
        send_item(make_item(CMD_DUE, 31'd93, 31'd7));
        send_item(make_item(CMD_DUE, 31'd101, 31'd5));
        send_item(make_item(CMD_DUE, 31'd101, 31'd6));
        send_item(make_item(CMD_DUE, 31'd201, 31'd0));
        send_item(make_item(CMD_DUE, 31'd200, 31'd100));
        // Starting below the first cycle: the interval index rounds toward zero.
        send_item(make_item(CMD_DUE, 31'd95, 31'd8));
        send_item(make_item(CMD_INIT, 31'd99, '0));
        send_item(make_item(CMD_INIT, 31'd200, '0));
        send_item(make_item(CMD_INIT, 31'd201, '0));
        // A last cycle of zero ends the schedule right at the start.
        configure(1'b0, '0, 31'd7, 32'd0, 5'd0);
        send_item(make_item(CMD_INIT, 31'd0, '0));
        send_item(make_item(CMD_INIT, 31'd5, '0));
        send_item(make_item(CMD_DUE, 31'd3, 31'd1));
        // A zero period behaves as a period of one.
        configure(1'b0, '0, '0, NO_END, 5'd0);
        send_item(make_item(CMD_DUE, 31'd10, 31'd1));
        configure(1'b0, CYC_MAX, CYC_MAX, 32'h7FFF_FFFF, 5'd0);
        send_item(make_item(CMD_DUE, '0, CYC_MAX));
        send_item(make_item(CMD_DUE, CYC_MAX, CYC_MAX));
        send_item(make_item(CMD_INIT, CYC_MAX - 31'd1, '0));
    endtask

    // Fills the whole table first, so later list checks never read an unwritten slot.
    task automatic test_cycle_list();
        configure(1'b1, '0, 31'd1, NO_END, 5'd0);
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (i == 0)
                send_item(make_item(CMD_LOAD, '0, '0, 4'(i), '0));
            else if (i == 1)
                send_item(make_item(CMD_LOAD, '0, '0, 4'(i), 31'd1007));
            else if (i == LIST_DEPTH - 1)
                send_item(make_item(CMD_LOAD, CYC_MAX, CYC_MAX, 4'(i), CYC_MAX));
            else
                send_item(make_item(CMD_LOAD, 31'($urandom), 31'($urandom), 4'(i),
                                    31'($urandom)));
        end
        send_item(make_item(CMD_INIT, '0, '0));
        configure(1'b1, '0, 31'd1, NO_END, 5'd16);
        send_item(make_item(CMD_DUE, 31'd500, 31'd507));
        send_item(make_item(CMD_INIT, CYC_MAX, '0));
        send_item(make_item(CMD_DUE, '0, 31'd1));
        // A count beyond the table depth is limited to the depth.
        configure(1'b1, '0, 31'd1, NO_END, 5'd31);
        send_item(make_item(CMD_INIT, CYC_MAX, '0));
        configure(1'b1, '0, 31'd1, NO_END, 5'd1);
        send_item(make_item(CMD_INIT, '0, '0));
        send_item(make_item(CMD_INIT, 31'd1007, '0));
    endtask

    task automatic test_random_schedules();
        logic [30:0] first, period;
        logic [31:0] last;
        logic [4:0]  count;
        for (int round = 0; round < 10; round++) begin
            case ($urandom_range(3))
                0: first = '0;
                1: first = CYC_MAX;
                2: first = 31'($urandom_range(1000));
                default: first = 31'($urandom);
            endcase
            case ($urandom_range(4))
                0: period = '0;
                1: period = 31'd1;
                2: period = 31'($urandom_range(50, 1));
                3: period = 31'($urandom);
                default: period = CYC_MAX;
            endcase
            case ($urandom_range(4))
                0: last = NO_END;
                1: last = '0;
                2: last = 32'(clamp_cyc(longint'(first) + $urandom_range(2000)));
                3: last = $urandom;
                default: last = 32'h7FFF_FFFF;
            endcase
            count = ($urandom_range(7) == 0) ? 5'($urandom_range(31, 17)) :
                                               5'($urandom_range(16));
            configure(1'(round % 2), first, period, last, count);
            no_idle <= (round == 3);
            repeat (72)
                send_item(random_item());
        end
    endtask

    // The result side holds off while items keep coming, so the input stalls.
    task automatic test_output_stall();
        configure(1'b0, 31'd40, 31'd3, NO_END, 5'd0);
        hold_len <= 300;
        hold_req <= hold_req + 1;
        repeat (12)
            send_item(random_item());
        wait_idle();
    endtask

    task automatic test_sender_drain();
        repeat (10)
            send_item(random_item());
        wait_idle();
        repeat (10)
            send_item(random_item());
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_schedule();
        test_periodic_rules();
        test_cycle_list();
        test_random_schedules();
        test_output_stall();
        test_sender_drain();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
